// File: src/assert_macros.svh
// assertion macros shared by the stepper pulse ramp limiter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/spr_pkg.sv
// types and constants of the stepper pulse ramp limiter
package spr_pkg;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_LOAD     = 2'd1,
      OP_OVERRIDE = 2'd2
   } opcode_type;

   // register word index (byte address bit 2)
   localparam logic CSR_MAX_TRAVEL = 1'b0;
   localparam logic CSR_DIR_INVERT = 1'b1;

   localparam logic [23:0]        RAMP_SPLIT   = 24'd2000;
   localparam logic signed [24:0] LIMIT_MARGIN = 25'sd50;
   localparam logic [4:0]         RAMP_DIV     = 5'd20;
   // ceil(2^20 / 20), exact quotient for any 16 bit ramp
   localparam logic [16:0]        RAMP_RECIP   = 17'd52429;
   localparam int                 RECIP_SHIFT  = 20;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [23:0] step_count;
      logic        direction;
      logic [15:0] period_us;
      logic [15:0] ramp_value;
      logic        override_value;
   } req_type;

   typedef struct packed {
      logic               step_level;
      logic               dir_level;
      logic               stepped;
      logic signed [23:0] position;
      logic [23:0]        steps_left;
      logic [15:0]        ramp_now;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_travel;
      logic        dir_invert;
   } cfg_type;

endpackage

// File: src/spr_csr.sv
// configuration registers behind the apb-style port
module spr_csr
   import spr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [15:0] max_travel_ff;
   logic        dir_invert_ff;
   logic        wr_en;
   logic        word_idx;

   assign csr_pready = 1'b1;
   assign word_idx   = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_travel_ff <= '0;
         dir_invert_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (word_idx)
            CSR_MAX_TRAVEL: max_travel_ff <= csr_pwdata[15:0];
            CSR_DIR_INVERT: dir_invert_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (word_idx)
         CSR_MAX_TRAVEL: csr_prdata = {16'd0, max_travel_ff};
         CSR_DIR_INVERT: csr_prdata = {31'd0, dir_invert_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.max_travel = max_travel_ff;
   assign cfg.dir_invert = dir_invert_ff;

endmodule

// File: src/spr_core.sv
// motion state and the single-pass update for one item
module spr_core
   import spr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    item_accept,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);
`include "assert_macros.svh"

   logic [31:0] elapsed_ff,   elapsed_in;
   logic        step_line_ff, step_line_in;
   logic [23:0] position_ff,  position_in;
   logic [23:0] remaining_ff, remaining_in;
   logic [15:0] ramp_ff,      ramp_in;
   // ramp / 20 kept as quotient and remainder, moved along with the ramp
   logic [11:0] ramp_q_ff,    ramp_q_in;
   logic [4:0]  ramp_r_ff,    ramp_r_in;
   logic [15:0] base_ff,      base_in;
   logic        dir_ff,       dir_in;
   logic        override_ff,  override_in;

   logic [31:0]        elapsed_inc;
   logic [16:0]        interval;
   logic               due;
   logic signed [24:0] pos_s;
   logic signed [24:0] upper;
   logic               allow;
   logic               fire;
   logic               ramp_dec;
   logic               ramp_inc;
   logic [32:0]        load_prod;
   logic [11:0]        load_q;
   logic [15:0]        load_q20;
   logic [15:0]        load_r;

   always_comb begin
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;
      interval    = {1'b0, base_ff} + {5'd0, ramp_q_ff};
      due         = elapsed_inc > {15'd0, interval};
      pos_s       = {position_ff[23], position_ff};
      upper       = $signed({9'd0, cfg.max_travel}) - LIMIT_MARGIN;
      if (override_ff)
         allow = 1'b1;
      else if (!dir_ff)
         allow = pos_s >= LIMIT_MARGIN;
      else
         allow = pos_s < upper;
      fire     = (item.opcode == OP_TICK) && due && (remaining_ff != '0) && allow;
      ramp_dec = (ramp_ff != '0) && (remaining_ff > RAMP_SPLIT);
      ramp_inc = (remaining_ff < RAMP_SPLIT) && (ramp_ff != '1);

      // quotient of a loaded ramp by reciprocal multiply
      load_prod = {17'd0, item.ramp_value} * {16'd0, RAMP_RECIP};
      load_q    = load_prod[RECIP_SHIFT +: 12];
      load_q20  = 16'({4'd0, load_q} * {11'd0, RAMP_DIV});
      load_r    = item.ramp_value - load_q20;
   end

   always_comb begin
      elapsed_in   = elapsed_ff;
      step_line_in = step_line_ff;
      position_in  = position_ff;
      remaining_in = remaining_ff;
      ramp_in      = ramp_ff;
      ramp_q_in    = ramp_q_ff;
      ramp_r_in    = ramp_r_ff;
      base_in      = base_ff;
      dir_in       = dir_ff;
      override_in  = override_ff;
      if (item_accept) begin
         unique case (item.opcode)
            OP_TICK: begin
               elapsed_in = elapsed_inc;
               if (fire) begin
                  elapsed_in   = '0;
                  step_line_in = ~step_line_ff;
                  position_in  = dir_ff ? position_ff + 24'd1 : position_ff - 24'd1;
                  remaining_in = remaining_ff - 24'd1;
                  if (ramp_dec) begin
                     ramp_in = ramp_ff - 16'd1;
                     if (ramp_r_ff == '0) begin
                        ramp_r_in = RAMP_DIV - 5'd1;
                        ramp_q_in = ramp_q_ff - 12'd1;
                     end else begin
                        ramp_r_in = ramp_r_ff - 5'd1;
                     end
                  end else if (ramp_inc) begin
                     ramp_in = ramp_ff + 16'd1;
                     if (ramp_r_ff == RAMP_DIV - 5'd1) begin
                        ramp_r_in = '0;
                        ramp_q_in = ramp_q_ff + 12'd1;
                     end else begin
                        ramp_r_in = ramp_r_ff + 5'd1;
                     end
                  end
               end
            end
            OP_LOAD: begin
               remaining_in = item.step_count;
               dir_in       = item.direction;
               base_in      = item.period_us;
               ramp_in      = item.ramp_value;
               ramp_q_in    = load_q;
               ramp_r_in    = load_r[4:0];
            end
            OP_OVERRIDE: begin
               override_in = item.override_value;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         step_line_ff <= 1'b0;
         position_ff  <= '0;
         remaining_ff <= '0;
         ramp_ff      <= '0;
         ramp_q_ff    <= '0;
         ramp_r_ff    <= '0;
         base_ff      <= '0;
         dir_ff       <= 1'b0;
         override_ff  <= 1'b0;
      end else begin
         elapsed_ff   <= elapsed_in;
         step_line_ff <= step_line_in;
         position_ff  <= position_in;
         remaining_ff <= remaining_in;
         ramp_ff      <= ramp_in;
         ramp_q_ff    <= ramp_q_in;
         ramp_r_ff    <= ramp_r_in;
         base_ff      <= base_in;
         dir_ff       <= dir_in;
         override_ff  <= override_in;
      end
   end

   always_comb begin
      result.step_level = step_line_in;
      result.dir_level  = dir_in ^ cfg.dir_invert;
      result.stepped    = item_accept & fire;
      result.position   = $signed(position_in);
      result.steps_left = remaining_in;
      result.ramp_now   = ramp_in;
   end

   `ASSERT_ALWAYS(a_ramp_split, clock, reset,
      (ramp_r_ff < RAMP_DIV) && (ramp_ff == 16'({4'd0, ramp_q_ff} * {11'd0, RAMP_DIV}) + 16'(ramp_r_ff)),
      "ramp quotient and remainder out of step with ramp")
   `ASSERT_NEXT(a_step_clears, clock, reset, item_accept && fire,
      (elapsed_ff == '0) && (remaining_ff == $past(remaining_ff) - 24'd1),
      "step did not clear elapsed count or count down")
   `ASSERT_NEXT(a_idle_holds, clock, reset, !item_accept,
      $stable(position_ff) && $stable(remaining_ff) && $stable(ramp_ff),
      "motion state changed without an item")

endmodule

// File: src/spr_rsp_buf.sv
// two-entry result buffer between the update logic and the rsp channel
module spr_rsp_buf
   import spr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
`include "assert_macros.svh"

   rsp_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   logic        pop;

   assign space     = count_ff != 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff != 2'd3, "result buffer count overflow")
   `ASSERT_IMPLIES(a_no_push_full, clock, reset, push, space, "item pushed into a full buffer")
   `ASSERT_ALWAYS(a_ptr_count, clock, reset,
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff),
      "buffer pointers disagree with count")

endmodule

// File: src/stepper_pulse_ramp_limiter_core.sv
// top level of the stepper pulse ramp limiter
//
//   port group   dir   handshake                    payload
//   req_*        in    req_valid / req_ready        req_data (req_type)
//   rsp_*        out   rsp_valid / rsp_ready        rsp_data (rsp_type)
//   csr_*        in    psel, penable, pwrite        paddr, pwdata / prdata
//
// one item per clock while the buffer has space: the state update is a single pass of
// compares and adds; the result lands in a two-entry buffer in the cycle after acceptance.
// a loaded ramp is divided by 20 with one 16x17 reciprocal multiply.
// sync active-high reset clears motion state, csrs, buffer pointers; no clearing pass.
// req_ready drops only when both buffer entries hold untaken results.
module stepper_pulse_ramp_limiter_core
   import spr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   rsp_type result;
   logic    space;
   logic    accept;

   assign req_ready = space;
   assign accept    = req_valid & req_ready;

   spr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .item        (req_data),
      .cfg         (cfg),
      .result      (result)
   );

   spr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: test/tb_stepper_pulse_ramp_limiter_core.sv
// self-checking testbench for the stepper pulse ramp limiter core
`timescale 1ns / 1ps

module tb_stepper_pulse_ramp_limiter_core;
   import spr_pkg::*;

   localparam logic [1:0]  OP_UNUSED       = 2'd3;
   localparam logic [2:0]  ADDR_MAX_TRAVEL = {CSR_MAX_TRAVEL, 2'b00};
   localparam logic [2:0]  ADDR_DIR_INVERT = {CSR_DIR_INVERT, 2'b00};
   localparam int          RAMP_KNEE       = 2000;
   localparam int          EDGE_MARGIN     = 50;
   localparam logic [15:0] RAMP_DIVISOR    = 16'd20;
   localparam int          CYCLE_LIMIT     = 200000;
   localparam int          DRAIN_CYCLES    = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   stepper_pulse_ramp_limiter_core DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // motor state as the block should hold it
   logic [15:0] travel_limit = '0;
   logic        invert_dir = 1'b0;
   logic [31:0] tick_count = '0;
   logic        pulse_line = 1'b0;
   logic [23:0] cur_pos = '0;
   logic [23:0] steps_to_go = '0;
   logic [15:0] ramp_level = '0;
   logic [15:0] period_base = '0;
   logic        heading = 1'b0;
   logic        ignore_limits = 1'b0;

   req_type pending_cmds[$];
   rsp_type predicted_status[$];
   bit      gaps_on = 1'b1;
   int      failures = 0;
   int      queued_items = 0;
   int      accepted_items = 0;
   int      checked_items = 0;
   int      steps_seen = 0;
   int      reg_writes = 0;
   int      cycle_count = 0;

   function automatic rsp_type advance_motor(req_type cmd);
      rsp_type     status;
      logic [31:0] interval;
      int          pos_now;
      int          upper_limit;
      logic        allowed;
      logic        made_step;
      made_step = 1'b0;
      case (cmd.opcode)
         OP_TICK: begin
            interval = 32'(period_base) + 32'(ramp_level / RAMP_DIVISOR);
            if (tick_count != '1) tick_count++;
            pos_now = int'($signed(cur_pos));
            upper_limit = int'(travel_limit) - EDGE_MARGIN;
            allowed = ignore_limits ||
                      (heading ? pos_now < upper_limit : pos_now >= EDGE_MARGIN);
            if (tick_count > interval && steps_to_go != 0 && allowed) begin
               if (ramp_level != 0 && steps_to_go > RAMP_KNEE) ramp_level--;
               if (steps_to_go < RAMP_KNEE && ramp_level != 16'hFFFF) ramp_level++;
               pulse_line = ~pulse_line;
               cur_pos = heading ? cur_pos + 24'd1 : cur_pos - 24'd1;
               steps_to_go = steps_to_go - 24'd1;
               tick_count = '0;
               made_step = 1'b1;
            end
         end
         OP_LOAD: begin
            steps_to_go = cmd.step_count;
            heading = cmd.direction;
            period_base = cmd.period_us;
            ramp_level = cmd.ramp_value;
         end
         OP_OVERRIDE: begin
            ignore_limits = cmd.override_value;
         end
         default: ;
      endcase
      status.step_level = pulse_line;
      status.dir_level = heading ^ invert_dir;
      status.stepped = made_step;
      status.position = cur_pos;
      status.steps_left = steps_to_go;
      status.ramp_now = ramp_level;
      return status;
   endfunction

   // register writes land in the predicted configuration as they happen
   always @(posedge clock) begin
      if (!reset && csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == CSR_MAX_TRAVEL) travel_limit = csr_pwdata[15:0];
         else invert_dir = csr_pwdata[0];
         reg_writes++;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_status.push_back(advance_motor(req_data));
            accepted_items++;
         end
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() != 0 && !(gaps_on && $urandom_range(99) < 10)) begin
               req_data <= pending_cmds.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_status.size() == 0) begin
               $error("unexpected result item: 0x%0h", rsp_data);
               failures++;
            end else begin
               want = predicted_status.pop_front();
               compare_field("step_level", 24'(want.step_level), 24'(rsp_data.step_level));
               compare_field("dir_level", 24'(want.dir_level), 24'(rsp_data.dir_level));
               compare_field("stepped", 24'(want.stepped), 24'(rsp_data.stepped));
               compare_field("position", want.position, rsp_data.position);
               compare_field("steps_left", want.steps_left, rsp_data.steps_left);
               compare_field("ramp_now", 24'(want.ramp_now), 24'(rsp_data.ramp_now));
               if (rsp_data.stepped === 1'b1) steps_seen++;
               checked_items++;
            end
         end
         rsp_ready <= !(gaps_on && $urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timed out after %0d cycles, %0d results outstanding",
                cycle_count, predicted_status.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic push_item(input logic [1:0] op, input logic [23:0] steps,
                            input logic dir, input logic [15:0] period,
                            input logic [15:0] ramp, input logic ovr);
      req_type cmd;
      cmd.opcode = op;
      cmd.step_count = steps;
      cmd.direction = dir;
      cmd.period_us = period;
      cmd.ramp_value = ramp;
      cmd.override_value = ovr;
      pending_cmds.push_back(cmd);
      queued_items++;
   endtask

   // item with the given opcode and random content in every other field
   task automatic push_random(input logic [1:0] op);
      push_item(op, 24'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                1'($urandom));
   endtask

   task automatic push_ticks(input int count);
      repeat (count) push_random(OP_TICK);
   endtask

   task automatic wait_idle;
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || predicted_status.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] travel, input logic invert);
      wait_idle();
      write_reg(ADDR_MAX_TRAVEL, {16'h0, travel});
      write_reg(ADDR_DIR_INVERT, {31'h0, invert});
      @(negedge clock);
   endtask

   // mostly complete moves with random content, the rest noise
   task automatic queue_random_phase(input int count);
      int          stop_at;
      int          pick;
      logic [23:0] steps;
      logic [15:0] period;
      logic [15:0] ramp;
      stop_at = queued_items + count;
      while (queued_items < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            if ($urandom_range(4) == 0)
               push_random(OP_OVERRIDE);
            case ($urandom_range(9))
               0:       steps = 24'($urandom);
               1, 2:    steps = 24'(24'd1990 + $urandom_range(20));
               default: steps = 24'($urandom_range(40, 1));
            endcase
            period = ($urandom_range(99) < 85) ? 16'($urandom_range(3)) : 16'($urandom);
            case ($urandom_range(9))
               0:       ramp = 16'($urandom);
               1:       ramp = 16'(16'hFFFF - $urandom_range(3));
               default: ramp = 16'($urandom_range(60));
            endcase
            push_item(OP_LOAD, steps, 1'($urandom), period, ramp, 1'($urandom));
            push_ticks($urandom_range(40, 1));
         end else if (pick < 85) begin
            push_random(OP_OVERRIDE);
            push_ticks($urandom_range(20, 1));
         end else if (pick < 95) begin
            push_random(2'($urandom_range(3)));
         end else begin
            push_ticks($urandom_range(30, 1));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: both directions blocked until the override is set
      push_item(OP_UNUSED, 24'hFFFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
      push_item(OP_LOAD, 24'd5, 1'b0, 16'd0, 16'd0, 1'b0);
      push_item(OP_TICK, '0, 1'b0, '0, '0, 1'b0);
      push_item(OP_LOAD, 24'd5, 1'b1, 16'd0, 16'd0, 1'b0);
      push_item(OP_TICK, '0, 1'b0, '0, '0, 1'b0);
      push_item(OP_OVERRIDE, '0, 1'b0, '0, '0, 1'b1);
      push_ticks(3);
      // run down through zero so the position wraps negative
      push_item(OP_LOAD, 24'd4, 1'b0, 16'd0, 16'd0, 1'b0);
      push_ticks(5);
      push_item(OP_OVERRIDE, '0, 1'b0, '0, '0, 1'b0);
      push_item(OP_LOAD, 24'hFFFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
      push_item(OP_TICK, '0, 1'b0, '0, '0, 1'b0);

      configure(16'hFFFF, 1'b1);
      // cross the ramp knee with a step on exactly 2000 remaining
      push_item(OP_LOAD, 24'd2003, 1'b1, 16'd0, 16'd10, 1'b0);
      push_ticks(6);
      push_item(OP_UNUSED, '0, 1'b0, '0, '0, 1'b0);
      queue_random_phase(280);

      configure(16'd30, 1'b0);
      queue_random_phase(280);

      // no idling on either side; a short move steps on every tick until it is done
      configure(16'hFFFF, 1'b0);
      gaps_on = 1'b0;
      push_item(OP_OVERRIDE, '0, 1'b0, '0, '0, 1'b1);
      push_item(OP_LOAD, 24'd3, 1'b1, 16'd0, 16'd10, 1'b0);
      push_ticks(30);
      queue_random_phase(280);
      wait_idle();
      gaps_on = 1'b1;

      configure(16'd0, 1'b1);
      queue_random_phase(250);

      configure(16'($urandom), 1'($urandom));
      queue_random_phase(280);

      configure(16'd50, 1'b0);
      queue_random_phase(280);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_status.size() != 0) begin
         $error("%0d expected results never arrived", predicted_status.size());
         failures++;
      end
      $display("run covered %0d items and %0d results, %0d step edges, %0d register writes",
               accepted_items, checked_items, steps_seen, reg_writes);
      $display("phases swept travel range and direction inversion, %0d cycles", cycle_count);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
